[design/bdftd_pkg.sv]
// ---------------------------------------------------------------------------
// bdftd_pkg
// Shared types, constants and helpers for the BDF time-derivative residual
// pipeline.
// ---------------------------------------------------------------------------
package bdftd_pkg;

	// Fixed-point format and field widths
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int UQ_W      = 31;
	localparam int SAT_W     = 70;

	// Width of the rounded term sums in the back end
	localparam int SUM_W     = 68;

	// Divider: dividend and quotient width, partial remainder width
	localparam int DIV_W = 65;
	localparam int REM_W = UQ_W + 1;

	// Derivative magnitudes at or above 2^CLAMP_BIT saturate whatever the residual
	localparam int CLAMP_BIT = 34;

	localparam logic signed [SAT_W-1:0] HALF70  = 70'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [SAT_W-1:0] MAX70   = 70'sd2147483647;
	localparam logic signed [SAT_W-1:0] MIN70   = -70'sd2147483648;

	// Register reset values
	localparam logic signed [DATA_W-1:0] ALPHA_NEW_RST   = 32'sd98304;
	localparam logic signed [DATA_W-1:0] ALPHA_NOW_RST   = -32'sd131072;
	localparam logic signed [DATA_W-1:0] ALPHA_PREV_RST  = 32'sd32768;
	localparam logic signed [DATA_W-1:0] ALPHA_PREV2_RST = 32'sd0;

	typedef enum logic [2:0] {
		REG_VOL_WEIGHT  = 3'd0,
		REG_RESID_AVG   = 3'd1,
		REG_ALPHA_NEW   = 3'd2,
		REG_ALPHA_NOW   = 3'd3,
		REG_ALPHA_PREV  = 3'd4,
		REG_ALPHA_PREV2 = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [UQ_W-1:0]          time_step;
		logic [UQ_W-1:0]          vol_new;
		logic [UQ_W-1:0]          vol_now;
		logic [UQ_W-1:0]          vol_prev;
		logic [UQ_W-1:0]          vol_prev2;
		logic signed [DATA_W-1:0] state_new;
		logic signed [DATA_W-1:0] state_now;
		logic signed [DATA_W-1:0] state_prev;
		logic signed [DATA_W-1:0] state_prev2;
		logic signed [DATA_W-1:0] resid_in;
		logic signed [DATA_W-1:0] resid_old;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] resid_out;
		logic                     saturated;
	} out_t;

	typedef struct packed {
		logic                     vol_weighted;
		logic                     resid_avg;
		logic signed [DATA_W-1:0] alpha_new;
		logic signed [DATA_W-1:0] alpha_now;
		logic signed [DATA_W-1:0] alpha_prev;
		logic signed [DATA_W-1:0] alpha_prev2;
	} cfg_t;

	// Coefficients and operands handed from the coefficient front end
	typedef struct packed {
		logic signed [DATA_W-1:0] c0;
		logic signed [DATA_W-1:0] c1;
		logic signed [DATA_W-1:0] c2;
		logic signed [DATA_W-1:0] c3;
		logic signed [DATA_W-1:0] st0;
		logic signed [DATA_W-1:0] st1;
		logic signed [DATA_W-1:0] st2;
		logic signed [DATA_W-1:0] st3;
		logic [UQ_W-1:0]          dt;
		logic signed [DATA_W-1:0] rp;
		logic                     flag;
	} coef_t;

	// Sideband that rides through a coefficient divider lane
	typedef struct packed {
		logic [62:0]              extra;
		logic signed [DATA_W-1:0] cm;
		logic                     cm_sat;
		logic                     neg;
		logic signed [DATA_W-1:0] st;
	} lane_tag_t;

	localparam int TAG_W = $bits(lane_tag_t);

	// Sideband that rides through the derivative divider
	typedef struct packed {
		logic [TAG_W-DATA_W-3:0]  pad;
		logic signed [DATA_W-1:0] rp;
		logic                     flag;
		logic                     neg;
	} main_tag_t;

	typedef struct packed {
		logic                     flag;
		logic signed [DATA_W-1:0] val;
	} sat_t;

	// Clip a wide signed value to signed 32 bits
	function automatic sat_t sat32(input logic signed [SAT_W-1:0] x);
		sat_t r;
		r.flag = 1'b0;
		r.val  = x[DATA_W-1:0];
		if (x > MAX70) begin
			r.flag = 1'b1;
			r.val  = MAX70[DATA_W-1:0];
		end else if (x < MIN70) begin
			r.flag = 1'b1;
			r.val  = MIN70[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

[design/bdftd_div.sv]
// ---------------------------------------------------------------------------
// bdftd_div
// Unsigned restoring divider, one quotient bit per pipeline stage, with a
// sideband tag that travels alongside.
// ---------------------------------------------------------------------------
module bdftd_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [bdftd_pkg::DIV_W-1:0]     dividend,
	input  logic [bdftd_pkg::UQ_W-1:0]      divisor,
	input  logic [bdftd_pkg::TAG_W-1:0]     tag_in,
	output logic                            out_valid,
	output logic [bdftd_pkg::DIV_W-1:0]     quotient,
	output logic [bdftd_pkg::TAG_W-1:0]     tag_out
);

	logic                          v_s   [bdftd_pkg::DIV_W];
	logic [bdftd_pkg::DIV_W-1:0]   dq_s  [bdftd_pkg::DIV_W];
	logic [bdftd_pkg::REM_W-1:0]   rem_s [bdftd_pkg::DIV_W];
	logic [bdftd_pkg::UQ_W-1:0]    dvs_s [bdftd_pkg::DIV_W];
	logic [bdftd_pkg::TAG_W-1:0]   tag_s [bdftd_pkg::DIV_W];

	for (genvar i = 0; i < bdftd_pkg::DIV_W; i++) begin : g_step
		logic                        pv;
		logic [bdftd_pkg::DIV_W-1:0] pdq;
		logic [bdftd_pkg::REM_W-1:0] prem;
		logic [bdftd_pkg::UQ_W-1:0]  pdvs;
		logic [bdftd_pkg::TAG_W-1:0] ptag;
		logic [bdftd_pkg::REM_W-1:0] rsh;
		logic [bdftd_pkg::REM_W:0]   diff;
		logic                        ge;

		if (i == 0) begin : g_first
			assign pv   = in_valid;
			assign pdq  = dividend;
			assign prem = '0;
			assign pdvs = divisor;
			assign ptag = tag_in;
		end else begin : g_next
			assign pv   = v_s[i-1];
			assign pdq  = dq_s[i-1];
			assign prem = rem_s[i-1];
			assign pdvs = dvs_s[i-1];
			assign ptag = tag_s[i-1];
		end

		// Shift in the next dividend bit and try the subtract
		assign rsh  = {prem[bdftd_pkg::REM_W-2:0], pdq[bdftd_pkg::DIV_W-1]};
		assign diff = {1'b0, rsh} - {2'b00, pdvs};
		assign ge   = !diff[bdftd_pkg::REM_W];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dq_s[i]  <= {pdq[bdftd_pkg::DIV_W-2:0], ge};
				rem_s[i] <= ge ? diff[bdftd_pkg::REM_W-1:0] : rsh;
				dvs_s[i] <= pdvs;
				tag_s[i] <= ptag;
			end
		end
	end

	assign out_valid = v_s[bdftd_pkg::DIV_W-1];
	assign quotient  = dq_s[bdftd_pkg::DIV_W-1];
	assign tag_out   = tag_s[bdftd_pkg::DIV_W-1];

`ifndef ASSERT_OFF
	// Final remainder must be below the divisor
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rem_s[bdftd_pkg::DIV_W-1] < {1'b0, dvs_s[bdftd_pkg::DIV_W-1]}))
		else $error("divider remainder not below divisor");
`endif

endmodule

[design/bdftd_coef.sv]
// ---------------------------------------------------------------------------
// bdftd_coef
// Front end: registers the request, forms alpha*volume products and the
// residual part, and produces the four saturated coefficients.
// ---------------------------------------------------------------------------
module bdftd_coef (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  bdftd_pkg::cfg_t     cfg,
	input  logic                in_valid,
	input  bdftd_pkg::in_t      in_data,
	output logic                coef_valid,
	output bdftd_pkg::coef_t    coef
);

	// Stage 1: request register
	logic           v_s1;
	bdftd_pkg::in_t in_s1;

	// Stage 2: products and operands
	logic                                 v_s2;
	logic signed [63:0]                   p_s2 [4];
	logic signed [bdftd_pkg::DATA_W-1:0]  st_s2 [4];
	logic [bdftd_pkg::UQ_W-1:0]           dt_s2;
	logic [bdftd_pkg::UQ_W-1:0]           vn_s2;
	logic signed [bdftd_pkg::DATA_W-1:0]  rp_s2;

	logic signed [bdftd_pkg::DATA_W:0]    rsum;

	bdftd_pkg::sat_t                      cm [4];
	logic signed [63:0]                   pmag [4];
	bdftd_pkg::lane_tag_t                 tin [1:3];
	bdftd_pkg::lane_tag_t                 tout [1:3];
	logic [bdftd_pkg::TAG_W-1:0]          tin_v [1:3];
	logic [bdftd_pkg::TAG_W-1:0]          tout_v [1:3];
	logic [bdftd_pkg::DIV_W-1:0]          q [1:3];
	logic                                 dv [1:3];

	bdftd_pkg::sat_t                      cn [1:3];
	logic signed [bdftd_pkg::SAT_W-1:0]   qs [1:3];

	logic                                 v_s3;
	bdftd_pkg::coef_t                     coef_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Mean of the two residuals, rounded toward minus infinity
	assign rsum = {in_s1.resid_in[bdftd_pkg::DATA_W-1], in_s1.resid_in}
		+ {in_s1.resid_old[bdftd_pkg::DATA_W-1], in_s1.resid_old};

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= in_data;
			p_s2[0] <= cfg.alpha_new * $signed({1'b0, in_s1.vol_new});
			p_s2[1] <= cfg.alpha_now * $signed({1'b0, in_s1.vol_now});
			p_s2[2] <= cfg.alpha_prev * $signed({1'b0, in_s1.vol_prev});
			p_s2[3] <= cfg.alpha_prev2 * $signed({1'b0, in_s1.vol_prev2});
			st_s2[0] <= in_s1.state_new;
			st_s2[1] <= in_s1.state_now;
			st_s2[2] <= in_s1.state_prev;
			st_s2[3] <= in_s1.state_prev2;
			dt_s2 <= (in_s1.time_step == '0) ? bdftd_pkg::UQ_W'(1) : in_s1.time_step;
			vn_s2 <= (in_s1.vol_new == '0) ? bdftd_pkg::UQ_W'(1) : in_s1.vol_new;
			rp_s2 <= cfg.resid_avg ? rsum[bdftd_pkg::DATA_W:1] : in_s1.resid_in;
		end
	end

	// Modal coefficients and product magnitudes for the divider lanes
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			cm[k]   = bdftd_pkg::sat32((bdftd_pkg::SAT_W'(p_s2[k]) + bdftd_pkg::HALF70)
				>>> bdftd_pkg::FRAC_BITS);
			pmag[k] = (p_s2[k] < 0) ? -p_s2[k] : p_s2[k];
		end
	end

	// Pack the sideband of each lane
	always_comb begin
		for (int k = 1; k < 4; k++) begin
			tin[k].extra  = '0;
			tin[k].cm     = cm[k].val;
			tin[k].cm_sat = cm[k].flag;
			tin[k].neg    = p_s2[k][63];
			tin[k].st     = st_s2[k];
		end
		tin[1].extra = {dt_s2, rp_s2};
		tin[2].extra = {31'd0, st_s2[0]};
		tin[3].extra = {30'd0, cm[0].val, cm[0].flag};
	end

	for (genvar k = 1; k < 4; k++) begin : g_lane
		assign tin_v[k] = tin[k];
		assign tout[k]  = tout_v[k];

		bdftd_div u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_s2),
			.dividend  (bdftd_pkg::DIV_W'($unsigned(pmag[k]))),
			.divisor   (vn_s2),
			.tag_in    (tin_v[k]),
			.out_valid (dv[k]),
			.quotient  (q[k]),
			.tag_out   (tout_v[k])
		);
	end

	// Non-modal past coefficients: signed quotient, saturated
	always_comb begin
		for (int k = 1; k < 4; k++) begin
			qs[k] = $signed(bdftd_pkg::SAT_W'(q[k]));
			if (tout[k].neg) begin
				qs[k] = -qs[k];
			end
			cn[k] = bdftd_pkg::sat32(qs[k]);
		end
	end

	// Stage 3: select coefficients by mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= dv[1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cfg.vol_weighted) begin
				coef_s3.c0   <= tout[3].extra[bdftd_pkg::DATA_W:1];
				coef_s3.c1   <= tout[1].cm;
				coef_s3.c2   <= tout[2].cm;
				coef_s3.c3   <= tout[3].cm;
				coef_s3.flag <= tout[3].extra[0] | tout[1].cm_sat | tout[2].cm_sat
					| tout[3].cm_sat;
			end else begin
				coef_s3.c0   <= cfg.alpha_new;
				coef_s3.c1   <= cn[1].val;
				coef_s3.c2   <= cn[2].val;
				coef_s3.c3   <= cn[3].val;
				coef_s3.flag <= cn[1].flag | cn[2].flag | cn[3].flag;
			end
			coef_s3.st0 <= tout[2].extra[bdftd_pkg::DATA_W-1:0];
			coef_s3.st1 <= tout[1].st;
			coef_s3.st2 <= tout[2].st;
			coef_s3.st3 <= tout[3].st;
			coef_s3.dt  <= tout[1].extra[62:bdftd_pkg::DATA_W];
			coef_s3.rp  <= tout[1].extra[bdftd_pkg::DATA_W-1:0];
		end
	end

	assign coef_valid = v_s3;
	assign coef       = coef_s3;

endmodule

[design/bdftd_deriv.sv]
// ---------------------------------------------------------------------------
// bdftd_deriv
// Back end: term products, rounded sum, division by the time step and the
// saturated residual update into the output register.
// ---------------------------------------------------------------------------
module bdftd_deriv (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                coef_valid,
	input  bdftd_pkg::coef_t    coef,
	output logic                res_valid,
	output bdftd_pkg::out_t     res
);

	// Stage 4: term products
	logic                                v_s4;
	logic signed [63:0]                  t_s4 [4];
	logic [bdftd_pkg::UQ_W-1:0]          dt_s4;
	logic signed [bdftd_pkg::DATA_W-1:0] rp_s4;
	logic                                flag_s4;

	// Stage 5: rounded terms, pairwise sums
	logic                                v_s5;
	logic signed [bdftd_pkg::SUM_W-1:0]  pa_s5;
	logic signed [bdftd_pkg::SUM_W-1:0]  pb_s5;
	logic [bdftd_pkg::UQ_W-1:0]          dt_s5;
	logic signed [bdftd_pkg::DATA_W-1:0] rp_s5;
	logic                                flag_s5;

	// Stage 6: full sum
	logic                                v_s6;
	logic signed [bdftd_pkg::SUM_W-1:0]  sum_s6;
	logic [bdftd_pkg::UQ_W-1:0]          dt_s6;
	logic signed [bdftd_pkg::DATA_W-1:0] rp_s6;
	logic                                flag_s6;

	// Stage 7: dividend magnitude and sign
	logic                                v_s7;
	logic [bdftd_pkg::DIV_W-1:0]         dvd_s7;
	logic [bdftd_pkg::UQ_W-1:0]          dt_s7;
	bdftd_pkg::main_tag_t                mt_s7;

	logic signed [bdftd_pkg::SAT_W-1:0]  rt [4];
	logic [bdftd_pkg::SUM_W-1:0]         smag;

	logic                                dv;
	logic [bdftd_pkg::DIV_W-1:0]         q;
	logic [bdftd_pkg::TAG_W-1:0]         tag_v;
	bdftd_pkg::main_tag_t                mt;

	logic [bdftd_pkg::CLAMP_BIT:0]       mq;
	logic signed [bdftd_pkg::CLAMP_BIT+1:0] dd;
	bdftd_pkg::sat_t                     fin;

	// Stage 8: output register
	logic                                v_s8;
	bdftd_pkg::out_t                     res_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s4 <= coef_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= dv;
		end
	end

	// Round each term half up
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rt[k] = (bdftd_pkg::SAT_W'(t_s4[k]) + bdftd_pkg::HALF70)
				>>> bdftd_pkg::FRAC_BITS;
		end
	end

	assign smag = (sum_s6 < 0) ? $unsigned(-sum_s6) : $unsigned(sum_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s4[0] <= coef.c0 * coef.st0;
			t_s4[1] <= coef.c1 * coef.st1;
			t_s4[2] <= coef.c2 * coef.st2;
			t_s4[3] <= coef.c3 * coef.st3;
			dt_s4   <= coef.dt;
			rp_s4   <= coef.rp;
			flag_s4 <= coef.flag;

			pa_s5   <= bdftd_pkg::SUM_W'(rt[0] + rt[1]);
			pb_s5   <= bdftd_pkg::SUM_W'(rt[2] + rt[3]);
			dt_s5   <= dt_s4;
			rp_s5   <= rp_s4;
			flag_s5 <= flag_s4;

			sum_s6  <= pa_s5 + pb_s5;
			dt_s6   <= dt_s5;
			rp_s6   <= rp_s5;
			flag_s6 <= flag_s5;

			dvd_s7     <= bdftd_pkg::DIV_W'({smag, {bdftd_pkg::FRAC_BITS{1'b0}}});
			dt_s7      <= dt_s6;
			mt_s7.pad  <= '0;
			mt_s7.rp   <= rp_s6;
			mt_s7.flag <= flag_s6;
			mt_s7.neg  <= sum_s6[bdftd_pkg::SUM_W-1];
		end
	end

	bdftd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.dividend  (dvd_s7),
		.divisor   (dt_s7),
		.tag_in    (mt_s7),
		.out_valid (dv),
		.quotient  (q),
		.tag_out   (tag_v)
	);

	assign mt = tag_v;

	// Clamp huge derivatives, restore sign, add residual part and saturate
	always_comb begin
		if (|q[bdftd_pkg::DIV_W-1:bdftd_pkg::CLAMP_BIT]) begin
			mq = {1'b1, {bdftd_pkg::CLAMP_BIT{1'b0}}};
		end else begin
			mq = {1'b0, q[bdftd_pkg::CLAMP_BIT-1:0]};
		end
		dd = $signed({1'b0, mq});
		if (mt.neg) begin
			dd = -dd;
		end
		fin = bdftd_pkg::sat32(bdftd_pkg::SAT_W'(dd) + bdftd_pkg::SAT_W'(mt.rp));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s8.resid_out <= fin.val;
			res_s8.saturated <= fin.flag | mt.flag;
		end
	end

	assign res_valid = v_s8;
	assign res       = res_s8;

endmodule

[design/bdf_time_derivative_residual_unit.sv]
// ---------------------------------------------------------------------------
// bdf_time_derivative_residual_unit
// Throughput: one request per cycle unless a held result is stalled.
// Depth: set by the 65-stage restoring dividers (three coefficient lanes
//   and the time-step division).
// Reset: arst_n clears all valid bits and loads the register reset values.
// ---------------------------------------------------------------------------
module bdf_time_derivative_residual_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  bdftd_pkg::in_t     in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output bdftd_pkg::out_t    out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	bdftd_pkg::cfg_t  cfg_q;
	logic             en;
	logic             coef_valid;
	bdftd_pkg::coef_t coef;

	// Advance the whole pipeline unless a held result is stalled
	assign en        = !out_valid || !out_stall;
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vol_weighted   <= 1'b1;
			cfg_q.resid_avg      <= 1'b0;
			cfg_q.alpha_new      <= bdftd_pkg::ALPHA_NEW_RST;
			cfg_q.alpha_now      <= bdftd_pkg::ALPHA_NOW_RST;
			cfg_q.alpha_prev     <= bdftd_pkg::ALPHA_PREV_RST;
			cfg_q.alpha_prev2    <= bdftd_pkg::ALPHA_PREV2_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bdftd_pkg::REG_VOL_WEIGHT:  cfg_q.vol_weighted   <= cfg_data[0];
				bdftd_pkg::REG_RESID_AVG:   cfg_q.resid_avg      <= cfg_data[0];
				bdftd_pkg::REG_ALPHA_NEW:   cfg_q.alpha_new      <= $signed(cfg_data);
				bdftd_pkg::REG_ALPHA_NOW:   cfg_q.alpha_now      <= $signed(cfg_data);
				bdftd_pkg::REG_ALPHA_PREV:  cfg_q.alpha_prev     <= $signed(cfg_data);
				bdftd_pkg::REG_ALPHA_PREV2: cfg_q.alpha_prev2    <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	bdftd_coef u_coef (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.coef_valid (coef_valid),
		.coef       (coef)
	);

	bdftd_deriv u_deriv (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.coef_valid (coef_valid),
		.coef       (coef),
		.res_valid  (out_valid),
		.res        (out_data)
	);

`ifndef ASSERT_OFF
	// A stalled result stays presented
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped under stall");

	// A stalled result keeps its value
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("result changed under stall");

	// Input is held back only while a result waits
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with empty output register");
`endif

endmodule

[dv/bdf_time_derivative_residual_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bdf_time_derivative_residual_checker
// Watches the request, result and register-write channels of the residual
// unit, predicts each updated residual in fixed point and compares results
// in order against the oldest prediction.
// ---------------------------------------------------------------------------
module bdf_time_derivative_residual_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  bdftd_pkg::in_t  in_data,
	input  logic            out_valid,
	input  logic            out_stall,
	input  bdftd_pkg::out_t out_data,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [31:0]     cfg_data,
	output int              pending,
	output int              fails
);

	// Shadow copy of the register file
	logic              modal_q;
	logic              cn_q;
	logic signed [31:0] a_new_q, a_now_q, a_prev_q, a_prev2_q;

	bdftd_pkg::out_t resid_queue[$];

	assign pending = resid_queue.size();

	// Round half up to the fixed-point grid
	function automatic longint round_fx(longint v);
		return (v + (longint'(1) <<< (bdftd_pkg::FRAC_BITS - 1))) >>> bdftd_pkg::FRAC_BITS;
	endfunction

	function automatic longint clip32(longint v, inout bit f);
		if (v > 64'sd2147483647) begin
			f = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			f = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic bdftd_pkg::out_t residual_update(bdftd_pkg::in_t x);
		longint vol[4], st[4], al[4], c[4];
		longint dt, vn, s, q, r, d, res;
		bit f;
		bdftd_pkg::out_t o;
		f = 1'b0;
		dt = longint'(x.time_step);
		vol[0] = longint'(x.vol_new);
		vol[1] = longint'(x.vol_now);
		vol[2] = longint'(x.vol_prev);
		vol[3] = longint'(x.vol_prev2);
		st[0] = longint'(x.state_new);
		st[1] = longint'(x.state_now);
		st[2] = longint'(x.state_prev);
		st[3] = longint'(x.state_prev2);
		al[0] = longint'(a_new_q);
		al[1] = longint'(a_now_q);
		al[2] = longint'(a_prev_q);
		al[3] = longint'(a_prev2_q);
		if (dt == 0)
			dt = 1;
		// Coefficients: alpha times volume, or scaled by the inverse new volume
		if (modal_q) begin
			for (int k = 0; k < 4; k++)
				c[k] = clip32(round_fx(al[k] * vol[k]), f);
		end else begin
			vn = (vol[0] == 0) ? 1 : vol[0];
			c[0] = al[0];
			for (int k = 1; k < 4; k++)
				c[k] = clip32((al[k] * vol[k]) / vn, f);
		end
		s = 0;
		for (int k = 0; k < 4; k++)
			s += round_fx(c[k] * st[k]);
		// Divide by the time step, clamping huge quotients
		q = s / dt;
		r = s % dt;
		if (q > 64'sd4294967296)
			q = 64'sd4294967296;
		if (q < -64'sd4294967296)
			q = -64'sd4294967296;
		d = (q <<< bdftd_pkg::FRAC_BITS)
			+ (r * (longint'(1) <<< bdftd_pkg::FRAC_BITS)) / dt;
		if (cn_q)
			res = d + ((longint'(x.resid_in) + longint'(x.resid_old)) >>> 1);
		else
			res = d + longint'(x.resid_in);
		res = clip32(res, f);
		o.resid_out = res[31:0];
		o.saturated = f;
		return o;
	endfunction

	// Track register writes, predict accepted requests, check results
	always @(posedge clk or negedge arst_n) begin
		bdftd_pkg::out_t exp_r;
		if (!arst_n) begin
			modal_q   <= 1'b1;
			cn_q      <= 1'b0;
			a_new_q   <= bdftd_pkg::ALPHA_NEW_RST;
			a_now_q   <= bdftd_pkg::ALPHA_NOW_RST;
			a_prev_q  <= bdftd_pkg::ALPHA_PREV_RST;
			a_prev2_q <= bdftd_pkg::ALPHA_PREV2_RST;
			resid_queue.delete();
			fails = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bdftd_pkg::REG_VOL_WEIGHT:  modal_q   <= cfg_data[0];
					bdftd_pkg::REG_RESID_AVG:   cn_q      <= cfg_data[0];
					bdftd_pkg::REG_ALPHA_NEW:   a_new_q   <= cfg_data;
					bdftd_pkg::REG_ALPHA_NOW:   a_now_q   <= cfg_data;
					bdftd_pkg::REG_ALPHA_PREV:  a_prev_q  <= cfg_data;
					bdftd_pkg::REG_ALPHA_PREV2: a_prev2_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				resid_queue.push_back(residual_update(in_data));
			if (out_valid && !out_stall) begin
				if (resid_queue.size() == 0) begin
					$error("unexpected result resid_out=%0d", out_data.resid_out);
					fails++;
				end else begin
					exp_r = resid_queue.pop_front();
					if (out_data.resid_out !== exp_r.resid_out) begin
						$error("resid_out: expected %0d, got %0d",
							exp_r.resid_out, out_data.resid_out);
						fails++;
					end
					if (out_data.saturated !== exp_r.saturated) begin
						$error("saturated: expected %0b, got %0b",
							exp_r.saturated, out_data.saturated);
						fails++;
					end
				end
			end
		end
	end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives the residual unit with directed corner requests and random
// requests under several register settings, with random gaps and
// back-pressure; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module testbench;

	localparam logic [2:0] REG_SPARE_LO = 3'd6;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;
	localparam int         DRAIN_CYCLES = 150;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            in_valid = 1'b0;
	logic            in_stall;
	bdftd_pkg::in_t  in_data = '0;
	logic            out_valid;
	logic            out_stall = 1'b0;
	bdftd_pkg::out_t out_data;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [2:0]      cfg_index = '0;
	logic [31:0]     cfg_data = '0;
	int              pending;
	int              fails;
	bit              quiet = 1'b0;
	int              stall_left = 0;

	always #4 clk = ~clk;

	bdf_time_derivative_residual_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bdf_time_derivative_residual_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending(pending), .fails(fails)
	);

	// Back-pressure in random bursts, none once quiet
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 7);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic [31:0] rand_signed();
		case ($urandom_range(0, 4))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 1 << 19) - (1 << 18);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] rand_unsigned();
		case ($urandom_range(0, 5))
			0: return 31'h7FFF_FFFF;
			1: return 31'($urandom_range(0, 2));
			2: return 31'($urandom_range(1 << 15, 1 << 18));
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic bdftd_pkg::in_t rand_request();
		bdftd_pkg::in_t x;
		x.time_step   = rand_unsigned();
		x.vol_new     = rand_unsigned();
		x.vol_now     = rand_unsigned();
		x.vol_prev    = rand_unsigned();
		x.vol_prev2   = rand_unsigned();
		x.state_new   = rand_signed();
		x.state_now   = rand_signed();
		x.state_prev  = rand_signed();
		x.state_prev2 = rand_signed();
		x.resid_in    = rand_signed();
		x.resid_old   = rand_signed();
		return x;
	endfunction

	task automatic send(bdftd_pkg::in_t x);
		in_data  <= x;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// Hold requests until every result is back and the pipe has drained
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(bit m, bit cn, logic [31:0] a0, logic [31:0] a1,
			logic [31:0] a2, logic [31:0] a3);
		drain();
		reg_write(bdftd_pkg::REG_VOL_WEIGHT, {31'($urandom), m});
		reg_write(bdftd_pkg::REG_RESID_AVG, {31'($urandom), cn});
		reg_write(bdftd_pkg::REG_ALPHA_NEW, a0);
		reg_write(bdftd_pkg::REG_ALPHA_NOW, a1);
		reg_write(bdftd_pkg::REG_ALPHA_PREV, a2);
		reg_write(bdftd_pkg::REG_ALPHA_PREV2, a3);
	endtask

	task automatic directed_set();
		bdftd_pkg::in_t x;
		x = '0;
		send(x);
		x = '1;
		x.state_new = 32'h7FFF_FFFF;
		send(x);
		x = '0;
		x.time_step = 31'h7FFF_FFFF;
		x.vol_new = 31'h7FFF_FFFF;
		x.vol_now = 31'h7FFF_FFFF;
		x.vol_prev = 31'h7FFF_FFFF;
		x.vol_prev2 = 31'h7FFF_FFFF;
		x.state_new = 32'h8000_0000;
		x.state_now = 32'h7FFF_FFFF;
		x.state_prev = 32'h8000_0000;
		x.state_prev2 = 32'h7FFF_FFFF;
		x.resid_in = 32'h8000_0000;
		x.resid_old = 32'h8000_0000;
		send(x);
		// zero time step and zero new volume
		x = rand_request();
		x.time_step = '0;
		x.vol_new = '0;
		send(x);
		x.time_step = 31'd1;
		x.resid_in = 32'h7FFF_FFFF;
		x.resid_old = 32'h7FFF_FFFF;
		send(x);
		x = rand_request();
		x.time_step = 31'h0001_0000;
		x.vol_new = 31'h0001_0000;
		x.vol_now = 31'h0001_0000;
		x.vol_prev = 31'h0001_0000;
		x.vol_prev2 = 31'h0001_0000;
		send(x);
	endtask

	initial begin
		#2_000_000;
		$display("** bdf_time_derivative_residual_unit: FAILED **");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, then the same corners in non-modal averaged mode
		directed_set();
		set_regs(1'b0, 1'b1, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_8000, 32'h0000_4000);
		directed_set();
		drain();
		reg_write(REG_SPARE_LO, $urandom);
		reg_write(REG_SPARE_HI, $urandom);
		directed_set();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_regs(1'b1, 1'b0, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_8000, '0);
				1: set_regs(1'b1, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000,
					32'h7FFF_FFFF, 32'h8000_0000);
				2: set_regs(1'b0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF,
					32'h8000_0000, 32'h7FFF_FFFF);
				3: set_regs(1'b0, 1'b1, '0, '0, '0, '0);
				default: set_regs(1'($urandom), 1'($urandom), rand_signed(), rand_signed(),
					rand_signed(), rand_signed());
			endcase
			if (ph == 7)
				quiet = 1'b1;
			for (int i = 0; i < 90; i++)
				send(rand_request());
		end

		drain();
		if (fails == 0)
			$display("** bdf_time_derivative_residual_unit: PASSED **");
		else
			$display("** bdf_time_derivative_residual_unit: FAILED **");
		$finish;
	end

endmodule
